// ===== sv/res_pkg.sv =====
// shared types and constants for the record exchange sort block
package res_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 32;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned KEY_W           = 32;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_STORE,
    ST_EMIT
  } sort_state_t;

endpackage

// ===== sv/record_exchange_sort_by_key.sv =====
// a record accepted while the set is not full is written to memory when accepted; after
// the final record the sort runs its prime, scan and store passes, then n results one per cycle
// throughput: one record per cycle while loading, set by the single memory write port
// the compare-swap scan reads one memory entry per cycle, so sorting dominates
// reset: synchronous active-low, empties the set and clears the dropped flag
// results cannot be stalled; out_valid marks each one for a single cycle
module record_exchange_sort_by_key #(
  parameter int unsigned MAX_RECORDS = res_pkg::MAX_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [res_pkg::ID_W-1:0]   in_record_id,
  input  logic [res_pkg::KEY_W-1:0]  in_price_key,
  input  logic                       in_last_record,
  output logic                       out_valid,
  output logic [res_pkg::ID_W-1:0]   out_sorted_id,
  output logic [res_pkg::KEY_W-1:0]  out_sorted_price,
  output logic                       out_end_of_run,
  output logic                       out_overflow
);
  import res_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RECORDS);

  rec_t          in_rec;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  rec_t          mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  rec_t          mem_rd_data;

  assign in_rec.id  = in_record_id;
  assign in_rec.key = in_price_key;

  res_seq #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_rec      (in_rec),
    .in_last     (in_last_record),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .out_strobe  (out_valid),
    .out_end     (out_end_of_run),
    .out_ovf     (out_overflow)
  );

  res_mem #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_sorted_id    = mem_rd_data.id;
  assign out_sorted_price = mem_rd_data.key;

endmodule

// ===== sv/res_mem.sv =====
// record memory, one write port and one registered read port
module res_mem #(
  parameter int unsigned MAX_RECORDS = res_pkg::MAX_RECORDS_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
  input  res_pkg::rec_t                  wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_RECORDS)-1:0] rd_addr,
  output res_pkg::rec_t                  rd_data
);
  import res_pkg::*;

  rec_t mem_r [MAX_RECORDS];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/res_seq.sv =====
// load, exchange sort and emission sequencer driving the record memory
module res_seq #(
  parameter int unsigned MAX_RECORDS = res_pkg::MAX_RECORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  res_pkg::rec_t                  in_rec,
  input  logic                           in_last,
  output logic                           mem_wr_en,
  output logic [$clog2(MAX_RECORDS)-1:0] mem_wr_addr,
  output res_pkg::rec_t                  mem_wr_data,
  output logic                           mem_rd_en,
  output logic [$clog2(MAX_RECORDS)-1:0] mem_rd_addr,
  input  res_pkg::rec_t                  mem_rd_data,
  output logic                           out_strobe,
  output logic                           out_end,
  output logic                           out_ovf
);
  import res_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  sort_state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  rec_t          hold_r, hold_nxt;
  logic          strobe_r, strobe_nxt;
  logic          end_r, end_nxt;
  logic          ovf_r, ovf_nxt;

  logic          accept;
  logic          full;
  logic [CW-1:0] n_after;
  logic          do_sort;
  logic          scan_more;
  logic          outer_more;
  logic          emit_last;

  assign accept     = start && (state_r == ST_IDLE);
  assign full       = (count_r == CW'(MAX_RECORDS));
  assign n_after    = full ? count_r : count_r + CW'(1);
  assign do_sort    = (n_after >= CW'(2));
  assign scan_more  = ((CW'(j_r) + CW'(1)) < count_r);
  assign outer_more = ((CW'(i_r) + CW'(2)) < count_r);
  assign emit_last  = ((CW'(i_r) + CW'(1)) == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_last) begin
          state_nxt = do_sort ? ST_PRIME : ST_EMIT;
        end
      end
      ST_PRIME: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!scan_more) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: state_nxt = outer_more ? ST_PRIME : ST_EMIT;
      ST_EMIT: begin
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    busy        = (state_r != ST_IDLE);
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[AW-1:0];
    mem_wr_data = in_rec;
    mem_rd_en   = 1'b0;
    mem_rd_addr = i_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    hold_nxt    = hold_r;
    strobe_nxt  = 1'b0;
    end_nxt     = 1'b0;
    ovf_nxt     = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          if (in_last) begin
            i_nxt = '0;
            j_nxt = AW'(1);
            if (do_sort) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
            end
          end
        end
      end
      ST_PRIME: begin
        hold_nxt    = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = j_r;
      end
      ST_SCAN: begin
        if (hold_r.key > mem_rd_data.key) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = j_r;
          mem_wr_data = hold_r;
          hold_nxt    = mem_rd_data;
        end
        if (scan_more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = j_r + AW'(1);
          j_nxt       = j_r + AW'(1);
        end
      end
      ST_STORE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = i_r;
        mem_wr_data = hold_r;
        if (outer_more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = i_r + AW'(1);
          i_nxt       = i_r + AW'(1);
          j_nxt       = i_r + AW'(2);
        end else begin
          i_nxt = '0;
        end
      end
      ST_EMIT: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = i_r;
        strobe_nxt  = 1'b1;
        end_nxt     = emit_last;
        ovf_nxt     = dropped_r;
        i_nxt       = i_r + AW'(1);
        if (emit_last) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          i_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      dropped_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      strobe_r  <= 1'b0;
      end_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      strobe_r  <= strobe_nxt;
      end_r     <= end_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_end    = end_r;
  assign out_ovf    = ovf_r;

endmodule

// ===== sim/tb_top.sv =====
// testbench for record_exchange_sort_by_key: set stimulus, sort prediction and result checks
`timescale 1ns / 1ps

module tb_top;
  import res_pkg::*;

  localparam int unsigned CAPACITY       = MAX_RECORDS_DEF;
  localparam int unsigned RANDOM_RECORDS = 130;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] price;
    logic             end_of_run;
    logic             overflow;
  } sorted_rec_t;

  class sort_scoreboard;
    logic [KEY_W-1:0] held_key [CAPACITY];
    logic [ID_W-1:0]  held_id  [CAPACITY];
    int unsigned      held_count;
    bit               dropped;
    sorted_rec_t      sorted_q [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      overflow_sets;

    function new();
      held_count    = 0;
      dropped       = 0;
      errors        = 0;
      checked       = 0;
      overflow_sets = 0;
    endfunction

    // store the record while the set has room, and on the last one of a set run the exchange sort
    function void note_record(logic [ID_W-1:0] id, logic [KEY_W-1:0] price, bit is_last);
      sorted_rec_t      r;
      logic [KEY_W-1:0] tk;
      logic [ID_W-1:0]  td;
      int unsigned      i;
      int unsigned      j;
      int unsigned      k;
      if (held_count < CAPACITY) begin
        held_key[held_count] = price;
        held_id[held_count]  = id;
        held_count++;
      end else begin
        dropped = 1'b1;
      end
      if (!is_last) return;
      for (i = 0; i + 1 < held_count; i++) begin
        for (j = i + 1; j < held_count; j++) begin
          if (held_key[i] > held_key[j]) begin
            tk = held_key[i];
            td = held_id[i];
            held_key[i] = held_key[j];
            held_id[i]  = held_id[j];
            held_key[j] = tk;
            held_id[j]  = td;
          end
        end
      end
      if (dropped) overflow_sets++;
      for (k = 0; k < held_count; k++) begin
        r.id         = held_id[k];
        r.price      = held_key[k];
        r.end_of_run = (k + 1 == held_count);
        r.overflow   = dropped;
        sorted_q.push_back(r);
      end
      held_count = 0;
      dropped    = 1'b0;
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic [KEY_W-1:0] price,
                               logic end_of_run, logic overflow);
      sorted_rec_t exp_r;
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result id %h price %h end %b overflow %b",
                 $time, id, price, end_of_run, overflow);
        return;
      end
      exp_r = sorted_q.pop_front();
      checked++;
      if (id !== exp_r.id) begin
        errors++;
        $display("%0t: sorted_id expected %h actual %h", $time, exp_r.id, id);
      end
      if (price !== exp_r.price) begin
        errors++;
        $display("%0t: sorted_price expected %h actual %h", $time, exp_r.price, price);
      end
      if (end_of_run !== exp_r.end_of_run) begin
        errors++;
        $display("%0t: end_of_run expected %b actual %b", $time, exp_r.end_of_run, end_of_run);
      end
      if (overflow !== exp_r.overflow) begin
        errors++;
        $display("%0t: overflow expected %b actual %b", $time, exp_r.overflow, overflow);
      end
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [ID_W-1:0]  in_record_id;
  logic [KEY_W-1:0] in_price_key;
  logic             in_last_record;
  logic             out_valid;
  logic [ID_W-1:0]  out_sorted_id;
  logic [KEY_W-1:0] out_sorted_price;
  logic             out_end_of_run;
  logic             out_overflow;

  sort_scoreboard   sb = new();
  logic [ID_W-1:0]  set_ids    [$];
  logic [KEY_W-1:0] set_prices [$];
  int unsigned      records_sent = 0;
  int unsigned      sets_sent    = 0;
  int unsigned      quiet_cycles = 0;

  record_exchange_sort_by_key #(.MAX_RECORDS(CAPACITY)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_record_id     (in_record_id),
    .in_price_key     (in_price_key),
    .in_last_record   (in_last_record),
    .out_valid        (out_valid),
    .out_sorted_id    (out_sorted_id),
    .out_sorted_price (out_sorted_price),
    .out_end_of_run   (out_end_of_run),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_sorted_id, out_sorted_price, out_end_of_run, out_overflow);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_price();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly small sets; the first two are a full set and an overflowing one
  function automatic int unsigned pick_set_size(int unsigned set_idx);
    int unsigned r;
    if (set_idx == 0) return CAPACITY;
    if (set_idx == 1) return CAPACITY + 1;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(CAPACITY + 1, CAPACITY + 4);
    if (r == 1) return CAPACITY;
    if (r < 5) return $urandom_range(9, CAPACITY - 1);
    return $urandom_range(1, 8);
  endfunction

  task automatic add_rec(logic [ID_W-1:0] id, logic [KEY_W-1:0] price);
    set_ids.push_back(id);
    set_prices.push_back(price);
  endtask

  // called right after a falling edge; returns right after a falling edge with start held
  task automatic send_item(logic [ID_W-1:0] id, logic [KEY_W-1:0] price, bit is_last);
    start          <= 1'b1;
    in_record_id   <= id;
    in_price_key   <= price;
    in_last_record <= is_last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_record(id, price, is_last);
    records_sent++;
    @(negedge clk);
  endtask

  task automatic play_set(bit burst);
    int unsigned g;
    int unsigned k;
    for (k = 0; k < set_ids.size(); k++) begin
      g = burst ? 0 : pick_gap();
      if (g > 0) begin
        start <= 1'b0;
        repeat (g) @(negedge clk);
      end
      send_item(set_ids[k], set_prices[k], k + 1 == set_ids.size());
    end
    set_ids.delete();
    set_prices.delete();
    sets_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned set_idx;
    int unsigned set_size;
    int unsigned target;
    int unsigned k;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_record_id   = '0;
    in_price_key   = '0;
    in_last_record = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single records at the extremes
    add_rec(16'hFFFF, 32'hFFFF_FFFF);
    play_set(1'b1);
    add_rec(16'h0000, 32'h0000_0000);
    play_set(1'b0);
    // mixed order with repeated keys
    add_rec(16'h0001, 32'hFFFF_FFFF);
    add_rec(16'h0002, 32'h8000_0000);
    add_rec(16'h0003, 32'h0000_0005);
    add_rec(16'h0004, 32'h0000_0005);
    add_rec(16'h0005, 32'h0000_0000);
    add_rec(16'h0006, 32'h0000_0005);
    add_rec(16'h0007, 32'h7FFF_FFFF);
    play_set(1'b1);
    // all keys equal
    for (k = 0; k < 5; k++) add_rec(ID_W'(16'h0010 + k), 32'h1234_5678);
    play_set(1'b0);
    // already ascending
    add_rec(16'h0020, 32'h0000_0000);
    add_rec(16'h0021, 32'h0000_0001);
    add_rec(16'h0022, 32'h0000_0002);
    add_rec(16'h0023, 32'hFFFF_FFFE);
    play_set(1'b1);

    target  = records_sent + RANDOM_RECORDS;
    set_idx = 0;
    while (records_sent < target) begin
      set_size = pick_set_size(set_idx);
      for (k = 0; k < set_size; k++) add_rec(ID_W'($urandom_range(0, 16'hFFFF)), pick_price());
      play_set($urandom_range(0, 3) == 0);
      if (set_idx == 3) wait_drained();
      set_idx++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d records in %0d sets, %0d of them overflowing",
             records_sent, sets_sent, sb.overflow_sets);
    $display("checked %0d sorted results, %0d still outstanding", sb.checked, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/res_pkg.sv
sv/res_mem.sv
sv/res_seq.sv
sv/record_exchange_sort_by_key.sv
sim/tb_top.sv
